### sv/wcp_pkg.sv
// Shared types and constants for the WAV container parser.
package wcp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [32:0] POS_MAX  = 33'h1FFFFFFFF;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR = 3'd1;
  localparam logic [2:0] ST_NOT_WAV   = 3'd2;
  localparam logic [2:0] ST_BAD_FMT   = 3'd3;
  localparam logic [2:0] ST_DATA_BAD  = 3'd4;
  localparam logic [2:0] ST_NO_FMT    = 3'd5;
  localparam logic [2:0] ST_NO_DATA   = 3'd6;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER, PH_CHUNK, PH_FMT, PH_SKIP, PH_DATA, PH_PEND, PH_DONE
  } phase_t;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        is_last;
    logic [2:0]  status;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_freq;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] payload_size;
  } out_item_t;

  localparam int QDEPTH = 2;

endpackage

### sv/wcp_fifo.sv
// Two-entry item queue between the input front and the parser back end.
module wcp_fifo import wcp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  in_item_t wr_item,
  output logic     full,
  output logic     rd_valid,
  input  logic     rd_en,
  output in_item_t rd_item
);
  in_item_t   mem_r [QDEPTH];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'(QDEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wptr_r] <= wr_item;
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) wptr_r <= ~wptr_r;
      if (rd_en) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

### sv/wcp_back.sv
// Parser back end: chunk walk, fmt latch, data pass-through and status.
module wcp_back import wcp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);
  phase_t       phase_r, phase_nxt;
  logic [31:0]  cnt_r, cnt_nxt;
  logic [31:0]  tag_r, tag_nxt;
  logic [31:0]  clen_r, clen_nxt;
  logic [31:0]  rlen_r, rlen_nxt;
  logic [32:0]  pos_r, pos_nxt;
  logic [7:0]   body_r [16];
  logic         fseen_r, fseen_nxt;
  logic         oval_r;
  out_item_t    oitem_r, oitem_nxt;

  logic         emit, emit_data, last_nxt;
  logic [2:0]   st;
  logic         body_we;
  logic [3:0]   body_idx;
  logic         go;
  logic [7:0]   b;
  logic [33:0]  psum;
  logic [32:0]  pos_a;

  assign b  = q_item.byte_value;
  assign go = q_valid && (!oval_r || !out_stall);
  assign q_pop = go;

  // saturating add to position
  function automatic logic [32:0] sat_add(input logic [32:0] p, input logic [32:0] n);
    logic [33:0] s;
    s = {1'b0, p} + {1'b0, n};
    return s[33] ? POS_MAX : s[32:0];
  endfunction

  // next-state logic
  always_comb begin
    phase_nxt = phase_r; cnt_nxt = cnt_r; tag_nxt = tag_r; clen_nxt = clen_r;
    rlen_nxt = rlen_r; pos_nxt = pos_r; fseen_nxt = fseen_r;
    emit = 1'b0; emit_data = 1'b0; last_nxt = 1'b0; st = ST_OK;
    body_we = 1'b0; body_idx = cnt_r[3:0];
    psum = '0; pos_a = '0;
    if (phase_r == PH_PEND) begin
      emit = 1'b1; st = fseen_r ? ST_OK : ST_NO_FMT;
    end else if (phase_r == PH_DONE) begin
      emit = 1'b0;
    end else if (q_item.action == ACT_END) begin
      emit = 1'b1;
      unique case (phase_r)
        PH_HEADER: st = ST_SHORT_HDR;
        PH_FMT:    st = ST_BAD_FMT;
        PH_DATA:   st = ST_DATA_BAD;
        default:   st = fseen_r ? ST_NO_DATA : ST_NO_FMT;
      endcase
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          if (cnt_r < 32'd4 || cnt_r >= 32'd8) tag_nxt = {tag_r[23:0], b};
          else rlen_nxt = rlen_r | ({24'd0, b} << {cnt_r[1:0], 3'd0});
          if (cnt_r == 32'd3) clen_nxt = {tag_r[23:0], b};
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_r == 32'd11) begin
            if (clen_r != TAG_RIFF || {tag_r[23:0], b} != TAG_WAVE) begin
              emit = 1'b1; st = ST_NOT_WAV;
            end else begin
              clen_nxt = '0; pos_nxt = 33'd12;
              psum = {2'b0, rlen_r} + 34'd8;
              if (34'd12 >= psum) begin
                emit = 1'b1; st = fseen_r ? ST_NO_DATA : ST_NO_FMT;
              end else begin
                phase_nxt = PH_CHUNK; cnt_nxt = '0;
              end
            end
          end
        end
        PH_CHUNK: begin
          if (cnt_r < 32'd4) tag_nxt = {tag_r[23:0], b};
          if (cnt_r == 32'd0) clen_nxt = '0;
          else if (cnt_r >= 32'd4)
            clen_nxt = clen_r | ({24'd0, b} << {cnt_r[1:0], 3'd0});
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_r == 32'd7) begin
            cnt_nxt = '0;
            pos_a = sat_add(pos_r, 33'd8);
            pos_nxt = pos_a;
            if (tag_r == TAG_FMT) begin
              if (clen_nxt < 32'd16) begin
                emit = 1'b1; st = ST_BAD_FMT;
              end else begin
                pos_nxt = sat_add(pos_a, {1'b0, clen_nxt}); phase_nxt = PH_FMT;
              end
            end else if (tag_r == TAG_DATA) begin
              if (clen_nxt == 32'd0) begin
                emit = 1'b1; st = ST_DATA_BAD;
              end else phase_nxt = PH_DATA;
            end else begin
              pos_nxt = sat_add(pos_a, {1'b0, clen_nxt});
              if (clen_nxt == 32'd0) begin
                psum = {2'b0, rlen_r} + 34'd8;
                if ({1'b0, pos_nxt} >= psum) begin
                  emit = 1'b1; st = fseen_r ? ST_NO_DATA : ST_NO_FMT;
                end else phase_nxt = PH_CHUNK;
              end else phase_nxt = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          body_we = 1'b1;
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_r[3:0] == 4'd15) begin
            fseen_nxt = 1'b1; clen_nxt = clen_r - 32'd16; cnt_nxt = '0;
            if (clen_r == 32'd16) begin
              psum = {2'b0, rlen_r} + 34'd8;
              if ({1'b0, pos_r} >= psum) begin
                emit = 1'b1; st = ST_NO_DATA;
              end else phase_nxt = PH_CHUNK;
            end else phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          clen_nxt = clen_r - 32'd1;
          if (clen_r == 32'd1) begin
            psum = {2'b0, rlen_r} + 34'd8;
            if ({1'b0, pos_r} >= psum) begin
              emit = 1'b1; st = fseen_r ? ST_NO_DATA : ST_NO_FMT;
            end else begin
              phase_nxt = PH_CHUNK; cnt_nxt = '0;
            end
          end
        end
        PH_DATA: begin
          emit_data = 1'b1;
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_nxt == clen_r) begin
            last_nxt = 1'b1; phase_nxt = PH_PEND;
          end
        end
        default: ;
      endcase
    end
    if (emit) phase_nxt = PH_DONE;
  end

  // result item: status with fmt fields on success, else a data byte
  always_comb begin
    oitem_nxt = '0;
    if (emit) begin
      oitem_nxt.kind    = 1'b1;
      oitem_nxt.is_last = 1'b1;
      oitem_nxt.status  = st;
      if (st == ST_OK) begin
        oitem_nxt.audio_format  = {body_r[1], body_r[0]};
        oitem_nxt.channel_count = {body_r[3], body_r[2]};
        oitem_nxt.sample_freq   = {body_r[7], body_r[6], body_r[5], body_r[4]};
        oitem_nxt.byte_rate     = {body_r[11], body_r[10], body_r[9], body_r[8]};
        oitem_nxt.block_align   = {body_r[13], body_r[12]};
        oitem_nxt.sample_bits   = {body_r[15], body_r[14]};
        oitem_nxt.payload_size  = clen_r;
      end
    end else begin
      oitem_nxt.data_byte = b;
      oitem_nxt.is_last   = last_nxt;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (go && (emit || emit_data)) oitem_r <= oitem_nxt;
    if (!rst_n) begin
      phase_r <= PH_HEADER; cnt_r <= '0; tag_r <= '0; clen_r <= '0;
      rlen_r <= '0; pos_r <= '0; fseen_r <= 1'b0; oval_r <= 1'b0;
      for (int i = 0; i < 16; i++) body_r[i] <= '0;
    end else begin
      if (go && body_we) body_r[body_idx] <= b;
      if (go) begin
        phase_r <= phase_nxt; cnt_r <= cnt_nxt; tag_r <= tag_nxt;
        clen_r <= clen_nxt; rlen_r <= rlen_nxt; pos_r <= pos_nxt;
        fseen_r <= fseen_nxt;
      end
      if (go) oval_r <= emit || emit_data;
      else if (!out_stall) oval_r <= 1'b0;
    end
  end

  assign out_valid = oval_r;
  assign out_item  = oitem_r;
endmodule

### sv/wav_container_parser_unit.sv
// Top level of the WAV container parser.
// Takes a WAV file one byte per item plus an end-of-stream item, and returns
// audio data bytes followed by one final status item carrying the fmt fields on success.
// Sustained rate is one item per cycle: a two-entry queue decouples the input
// from the parser back end, which handles one queued item per cycle and
// holds its result in an output register. A result passes through the queue
// and then the output register; a stalled output holds the back end, and
// the input stalls once the queue is full. After the status item, further
// input items are taken and give no result until reset.
module wav_container_parser_unit import wcp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);
  logic     full, q_valid, q_pop;
  in_item_t q_item;

  assign in_stall = full;

  wcp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_en(in_valid && !full), .wr_item(in_item), .full(full),
    .rd_valid(q_valid), .rd_en(q_pop), .rd_item(q_item)
  );

  wcp_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );
endmodule

### verif/wav_container_parser_unit_tb.sv
// Testbench for the WAV container parser: directed header table, then a random well-formed file.
module wav_container_parser_unit_tb import wcp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  wav_container_parser_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // directed rows; quiet marks a row known to give no result
  typedef struct packed {
    in_item_t it;
    logic     quiet;
  } dir_row_t;

  localparam int DIR_N = 20;
  dir_row_t dir_tab [DIR_N] = '{
    '{'{ACT_BYTE, 8'h52}, 1'b1}, '{'{ACT_BYTE, 8'h49}, 1'b1},  // "RI"
    '{'{ACT_BYTE, 8'h46}, 1'b1}, '{'{ACT_BYTE, 8'h46}, 1'b1},  // "FF"
    '{'{ACT_BYTE, 8'hFF}, 1'b1}, '{'{ACT_BYTE, 8'hFF}, 1'b1},  // riff size, max
    '{'{ACT_BYTE, 8'hFF}, 1'b1}, '{'{ACT_BYTE, 8'hFF}, 1'b1},
    '{'{ACT_BYTE, 8'h57}, 1'b1}, '{'{ACT_BYTE, 8'h41}, 1'b1},  // "WA"
    '{'{ACT_BYTE, 8'h56}, 1'b1}, '{'{ACT_BYTE, 8'h45}, 1'b1},  // "VE"
    '{'{ACT_BYTE, 8'h66}, 1'b1}, '{'{ACT_BYTE, 8'h6D}, 1'b1},  // "fm"
    '{'{ACT_BYTE, 8'h74}, 1'b1}, '{'{ACT_BYTE, 8'h20}, 1'b1},  // "t "
    '{'{ACT_BYTE, 8'h10}, 1'b1}, '{'{ACT_BYTE, 8'h00}, 1'b1},  // fmt size 16
    '{'{ACT_BYTE, 8'h00}, 1'b1}, '{'{ACT_BYTE, 8'h00}, 1'b1}
  };

  // parser shadow state
  phase_t      ps_phase;
  logic [31:0] ps_count;
  logic [31:0] ps_tag;
  logic [31:0] ps_clen;
  logic [31:0] ps_rlen;
  logic [32:0] ps_pos;
  logic [7:0]  ps_body [16];
  logic        ps_fmt_seen;
  logic        ps_done;

  out_item_t   expected_q [$];
  in_item_t    stim_q [$];
  int          mismatches;
  int          send_pct;
  int          recv_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] body16(int i);
    return {ps_body[i+1], ps_body[i]};
  endfunction

  // final status item; format fields only on success
  task automatic push_status(logic [2:0] st);
    out_item_t o;
    o = '0;
    o.kind    = 1'b1;
    o.is_last = 1'b1;
    o.status  = st;
    if (st == ST_OK) begin
      o.audio_format  = body16(0);
      o.channel_count = body16(2);
      o.sample_freq   = {body16(6), body16(4)};
      o.byte_rate     = {body16(10), body16(8)};
      o.block_align   = body16(12);
      o.sample_bits   = body16(14);
      o.payload_size  = ps_clen;
    end
    expected_q.push_back(o);
    ps_done = 1'b1;
  endtask

  task automatic pos_add(logic [31:0] n);
    logic [33:0] s;
    s = {1'b0, ps_pos} + {2'b0, n};
    ps_pos = (s > {1'b0, POS_MAX}) ? POS_MAX : s[32:0];
  endtask

  // chunk boundary: stop once the walk limit is reached
  task automatic at_boundary();
    if ({1'b0, ps_pos} >= {2'b0, ps_rlen} + 34'd8) begin
      push_status(ps_fmt_seen ? ST_NO_DATA : ST_NO_FMT);
    end else begin
      ps_phase = PH_CHUNK;
      ps_count = 0;
    end
  endtask

  task automatic predict(in_item_t it);
    logic [31:0] b;
    out_item_t   o;
    b = {24'd0, it.byte_value};
    if (ps_done) return;
    if (ps_phase == PH_PEND) begin
      push_status(ps_fmt_seen ? ST_OK : ST_NO_FMT);
      return;
    end
    if (it.action == ACT_END) begin
      case (ps_phase)
        PH_HEADER: push_status(ST_SHORT_HDR);
        PH_FMT:    push_status(ST_BAD_FMT);
        PH_DATA:   push_status(ST_DATA_BAD);
        default:   push_status(ps_fmt_seen ? ST_NO_DATA : ST_NO_FMT);
      endcase
      return;
    end
    case (ps_phase)
      PH_HEADER: begin
        if (ps_count < 4 || ps_count >= 8) ps_tag = {ps_tag[23:0], b[7:0]};
        else ps_rlen |= b << (8 * (ps_count - 4));
        if (ps_count == 3) ps_clen = ps_tag;
        ps_count++;
        if (ps_count == 12) begin
          if (ps_clen != TAG_RIFF || ps_tag != TAG_WAVE) begin
            push_status(ST_NOT_WAV);
          end else begin
            ps_clen = 0;
            ps_pos  = 33'd12;
            at_boundary();
          end
        end
      end
      PH_CHUNK: begin
        if (ps_count == 0) ps_clen = 0;
        if (ps_count < 4) ps_tag = {ps_tag[23:0], b[7:0]};
        else ps_clen |= b << (8 * (ps_count - 4));
        ps_count++;
        if (ps_count >= 8) begin
          pos_add(32'd8);
          ps_count = 0;
          if (ps_tag == TAG_FMT) begin
            if (ps_clen < 16) begin
              push_status(ST_BAD_FMT);
            end else begin
              pos_add(ps_clen);
              ps_phase = PH_FMT;
            end
          end else if (ps_tag == TAG_DATA) begin
            if (ps_clen == 0) push_status(ST_DATA_BAD);
            else ps_phase = PH_DATA;
          end else begin
            pos_add(ps_clen);
            if (ps_clen == 0) at_boundary();
            else ps_phase = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        ps_body[ps_count[3:0]] = b[7:0];
        ps_count++;
        if (ps_count >= 16) begin
          ps_fmt_seen = 1'b1;
          ps_clen -= 16;
          ps_count = 0;
          if (ps_clen == 0) at_boundary();
          else ps_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        ps_clen--;
        if (ps_clen == 0) at_boundary();
      end
      PH_DATA: begin
        o = '0;
        o.data_byte = b[7:0];
        ps_count++;
        if (ps_count == ps_clen) begin
          o.is_last = 1'b1;
          ps_phase  = PH_PEND;
        end
        expected_q.push_back(o);
      end
      default: ps_done = 1'b1;
    endcase
  endtask

  // stream builders
  task automatic add_byte(logic [7:0] v);
    stim_q.push_back('{ACT_BYTE, v});
  endtask

  task automatic add_tag(logic [31:0] t);
    for (int i = 3; i >= 0; i--) add_byte(t[8*i +: 8]);
  endtask

  task automatic add_le32(logic [31:0] v);
    for (int i = 0; i < 4; i++) add_byte(v[8*i +: 8]);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // present one item, with random idle cycles ahead of it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    predict(it);
  endtask

  // result side: random stall, compare each accepted item
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", out_item);
        end else begin
          want = expected_q.pop_front();
          if (out_item !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected %p", want);
              $display("          actual   %p", out_item);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  initial begin
    int n;
    int len;
    int before_n;
    int total;
    logic [31:0] tag;
    in_valid   = 1'b0;
    in_item    = '0;
    out_stall  = 1'b0;
    rst_n      = 1'b0;
    mismatches = 0;
    send_pct   = 31;
    recv_pct   = 82;
    ps_phase    = PH_HEADER;
    ps_count    = 0;
    ps_tag      = 0;
    ps_clen     = 0;
    ps_rlen     = 0;
    ps_pos      = 0;
    ps_fmt_seen = 1'b0;
    ps_done     = 1'b0;
    foreach (ps_body[i]) ps_body[i] = 8'h00;

    // rest of the file: fmt body, then a mix of chunks, then the data chunk
    for (int i = 0; i < 16; i++) add_byte(rand_byte());
    n = $urandom_range(4, 8);
    for (int c = 0; c < n; c++) begin
      if ($urandom_range(2) == 0) begin
        len = $urandom_range(16, 22);
        add_tag(TAG_FMT);
        add_le32(len);
        for (int i = 0; i < len; i++) add_byte(rand_byte());
      end else begin
        tag = $urandom;
        if (tag == TAG_FMT || tag == TAG_DATA) tag = ~tag;
        len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
        add_tag(tag);
        add_le32(len);
        for (int i = 0; i < len; i++) add_byte(rand_byte());
      end
    end
    len = $urandom_range(1100, 1240);
    add_tag(TAG_DATA);
    add_le32(len);
    for (int i = 0; i < len; i++) add_byte(rand_byte());
    // this one releases the status; the rest are ignored
    stim_q.push_back('{1'($urandom), 8'($urandom)});
    for (int i = 0; i < 6; i++) stim_q.push_back('{1'($urandom), 8'($urandom)});
    stim_q.push_back('{ACT_END, 8'h00});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    total = DIR_N + stim_q.size();
    for (int i = 0; i < DIR_N; i++) begin
      before_n = expected_q.size();
      send_item(dir_tab[i].it);
      if (dir_tab[i].quiet && expected_q.size() != before_n) begin
        mismatches++;
        if (mismatches <= 10) $display("row %0d should give no result", i);
      end
    end
    foreach (stim_q[i]) begin
      if (DIR_N + i == total / 3) begin
        send_pct = 82;
        recv_pct = 31;
      end else if (DIR_N + i == 2 * total / 3) begin
        send_pct = 0;
        recv_pct = 0;
      end
      send_item(stim_q[i]);
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### wav_container_parser_unit.f
sv/wcp_pkg.sv
sv/wcp_fifo.sv
sv/wcp_back.sv
sv/wav_container_parser_unit.sv
verif/wav_container_parser_unit_tb.sv
